### design/bcp_pkg.sv
// ----------------------------------------------------------------------------
// bcp_pkg: shared types and constants of the barycentric color picker
// Holds the transaction structs, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package bcp_pkg;

  localparam int CoordBits   = 11;
  localparam int CompBits    = 8;
  localparam int Lanes       = 3;
  localparam int QuoBits     = 8;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 24;
  localparam int VertexBits  = 2 * CoordBits;

  localparam logic [CompBits-1:0]  ColorMax     = 8'd255;
  localparam logic [CompBits-1:0]  GrayLevel    = 8'd85;
  localparam logic [CoordBits-1:0] WidthReset   = 11'd640;
  localparam logic [CoordBits-1:0] BarTopReset  = 11'd440;

  typedef enum logic [CfgIdxBits-1:0] {
    RegVertexR    = 3'd0,
    RegVertexG    = 3'd1,
    RegVertexB    = 3'd2,
    RegScreenWidth = 3'd3,
    RegBarTop     = 3'd4,
    RegBarColor   = 3'd5
  } bcp_reg_e;

  typedef struct packed {
    logic [CoordBits-1:0] cursor_x;
    logic [CoordBits-1:0] cursor_y;
  } bcp_in_t;

  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
    logic                in_bar;
    logic                outside_triangle;
  } bcp_out_t;

endpackage

### design/barycentric_color_picker_unit.sv
// Pipeline: 1 input register, 8 divider stages, 5 arithmetic stages, 8 divider stages,
//   1 output register; every stage is a flat register slice.
// Throughput: one transaction per cycle unless the skid entry is full.
// Reset: asynchronous, active low; clears valid bits and loads register defaults
//   (vertices 0, width 640, bar top 440, bar color 0).
// ----------------------------------------------------------------------------
// barycentric_color_picker_unit: cursor position to RGB color
// Gradient bar below the bar top, barycentric triangle colors above it.
// ----------------------------------------------------------------------------
module barycentric_color_picker_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  bcp_pkg::bcp_in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output bcp_pkg::bcp_out_t                     out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [bcp_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [bcp_pkg::CfgDataBits-1:0]       cfg_data_i
);
  import bcp_pkg::*;

  localparam int DiffBits = CoordBits + 1;        // signed vertex minus cursor
  localparam int ProdBits = 2 * DiffBits;         // signed cross product term
  localparam int NBits    = ProdBits + 1;         // signed weight numerator
  localparam int DetBits  = NBits + 2;            // signed determinant
  localparam int NfBits   = NBits + 1;            // weight after sign fix
  localparam int BarBits  = CoordBits + CompBits; // cursor_x times scaled color
  localparam int N1W      = 2 * CompBits;         // 255 * component
  localparam int N2W      = NBits + CompBits;     // 255 * weight
  localparam int D2W      = DetBits;
  localparam int Sb1W     = 2 * CoordBits + 1;
  localparam int Sb2W     = 2 + Lanes;

  // --------------------------------------------------------------------------
  // Config registers, unenforced: the user writes them only while the pipeline is empty
  // --------------------------------------------------------------------------
  logic [VertexBits-1:0] vtx_q [Lanes];
  logic [CoordBits-1:0]  width_q, bar_top_q;
  logic [CfgDataBits-1:0] bar_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lanes; i++) vtx_q[i] <= '0;
      width_q     <= WidthReset;
      bar_top_q   <= BarTopReset;
      bar_color_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegVertexR:     vtx_q[0]    <= cfg_data_i[VertexBits-1:0];
        RegVertexG:     vtx_q[1]    <= cfg_data_i[VertexBits-1:0];
        RegVertexB:     vtx_q[2]    <= cfg_data_i[VertexBits-1:0];
        RegScreenWidth: width_q     <= cfg_data_i[CoordBits-1:0];
        RegBarTop:      bar_top_q   <= cfg_data_i[CoordBits-1:0];
        RegBarColor:    bar_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a zero width behaves as a width of one
  logic [CoordBits-1:0] width_eff;
  assign width_eff = (width_q == '0) ? CoordBits'(1) : width_q;

  // global advance: the whole pipeline holds only when the skid entry is full
  logic en;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Stage 0: register the cursor, pick bar components and their maximum
  // --------------------------------------------------------------------------
  logic                           s0_v_q;
  logic [CoordBits-1:0]           s0_cx_q, s0_cy_q;
  logic                           s0_bar_q;
  logic [Lanes-1:0][N1W-1:0]      s0_num_q;
  logic [Lanes-1:0][CompBits-1:0] s0_den_q;
  logic [Lanes-1:0][N1W-1:0]      s0_num_d;
  logic [Lanes-1:0][CompBits-1:0] s0_den_d;

  always_comb begin
    logic [CompBits-1:0] comp [Lanes];
    logic [CompBits-1:0] mx;
    mx = '0;
    for (int l = 0; l < Lanes; l++) begin
      comp[l] = bar_color_q[l*CompBits +: CompBits];
      if (comp[l] > mx) mx = comp[l];
    end
    // an all-black bar color divides by one and stays black
    if (mx == '0) mx = CompBits'(1);
    for (int l = 0; l < Lanes; l++) begin
      s0_num_d[l] = {comp[l], {CompBits{1'b0}}} - N1W'(comp[l]);
      s0_den_d[l] = mx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_cx_q  <= in_data_i.cursor_x;
      s0_cy_q  <= in_data_i.cursor_y;
      s0_bar_q <= (in_data_i.cursor_y >= bar_top_q);
      s0_num_q <= s0_num_d;
      s0_den_q <= s0_den_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 1: scale the bar color so its largest component reaches 255
  // --------------------------------------------------------------------------
  logic                           d1_v;
  logic [Lanes-1:0][QuoBits-1:0]  d1_quo;
  logic [Sb1W-1:0]                d1_sb;

  bcp_div #(.NW(N1W), .DW(CompBits), .SBW(Sb1W)) u_div_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .num_i   (s0_num_q),
    .den_i   (s0_den_q),
    .sb_i    ({s0_cx_q, s0_cy_q, s0_bar_q}),
    .valid_o (d1_v),
    .quo_o   (d1_quo),
    .rem_o   (),
    .den_o   (),
    .sb_o    (d1_sb)
  );

  // --------------------------------------------------------------------------
  // Stage T1: vertex offsets from the cursor, bar numerators
  // --------------------------------------------------------------------------
  logic                              t1_v_q, t1_bar_q;
  logic signed [DiffBits-1:0]        t1_dx_q [Lanes];
  logic signed [DiffBits-1:0]        t1_dy_q [Lanes];
  logic [Lanes-1:0][BarBits-1:0]     t1_bn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
    end else if (en) begin
      t1_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [CoordBits-1:0] cx, cy;
    cx = d1_sb[Sb1W-1 -: CoordBits];
    cy = d1_sb[CoordBits:1];
    if (en) begin
      t1_bar_q <= d1_sb[0];
      for (int l = 0; l < Lanes; l++) begin
        t1_dx_q[l] <= $signed({1'b0, vtx_q[l][CoordBits-1:0]}) - $signed({1'b0, cx});
        t1_dy_q[l] <= $signed({1'b0, vtx_q[l][VertexBits-1:CoordBits]})
                      - $signed({1'b0, cy});
        t1_bn_q[l] <= BarBits'(cx) * BarBits'(d1_quo[l]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage T2: cross product terms, bar overflow test
  // --------------------------------------------------------------------------
  logic                          t2_v_q, t2_bar_q;
  logic signed [ProdBits-1:0]    t2_p_q [2*Lanes];
  logic [Lanes-1:0][BarBits-1:0] t2_bn_q;
  logic [Lanes-1:0]              t2_clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_v_q <= 1'b0;
    end else if (en) begin
      t2_v_q <= t1_v_q;
    end
  end

  // lanes: 0 red, 1 green, 2 blue
  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_bar_q  <= t1_bar_q;
      t2_bn_q   <= t1_bn_q;
      t2_p_q[0] <= t1_dy_q[2] * t1_dx_q[1];
      t2_p_q[1] <= t1_dx_q[2] * t1_dy_q[1];
      t2_p_q[2] <= t1_dx_q[2] * t1_dy_q[0];
      t2_p_q[3] <= t1_dy_q[2] * t1_dx_q[0];
      t2_p_q[4] <= t1_dy_q[1] * t1_dx_q[0];
      t2_p_q[5] <= t1_dx_q[1] * t1_dy_q[0];
      // quotient of 256 or more saturates
      for (int l = 0; l < Lanes; l++) begin
        t2_clamp_q[l] <= (t1_bn_q[l] >= {width_eff, {CompBits{1'b0}}});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage T3: weight numerators and determinant
  // --------------------------------------------------------------------------
  logic                          t3_v_q, t3_bar_q;
  logic signed [NBits-1:0]       t3_n_q [Lanes];
  logic signed [DetBits-1:0]     t3_det_q;
  logic [Lanes-1:0][BarBits-1:0] t3_bn_q;
  logic [Lanes-1:0]              t3_clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_v_q <= 1'b0;
    end else if (en) begin
      t3_v_q <= t2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [NBits-1:0] n0, n1, n2;
    n0 = NBits'(t2_p_q[0]) - NBits'(t2_p_q[1]);
    n1 = NBits'(t2_p_q[2]) - NBits'(t2_p_q[3]);
    n2 = NBits'(t2_p_q[4]) - NBits'(t2_p_q[5]);
    if (en) begin
      t3_bar_q   <= t2_bar_q;
      t3_bn_q    <= t2_bn_q;
      t3_clamp_q <= t2_clamp_q;
      t3_n_q[0]  <= n0;
      t3_n_q[1]  <= n1;
      t3_n_q[2]  <= n2;
      t3_det_q   <= DetBits'(n0) + DetBits'(n1) + DetBits'(n2);
    end
  end

  // --------------------------------------------------------------------------
  // Stage T4: flip signs to a positive determinant, decide outside
  // --------------------------------------------------------------------------
  logic                          t4_v_q, t4_bar_q, t4_out_q;
  logic signed [NfBits-1:0]      t4_n_q [Lanes];
  logic [DetBits-1:0]            t4_det_q;
  logic [Lanes-1:0][BarBits-1:0] t4_bn_q;
  logic [Lanes-1:0]              t4_clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t4_v_q <= 1'b0;
    end else if (en) begin
      t4_v_q <= t3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic                     neg, outside;
    logic signed [NfBits-1:0] nf [Lanes];
    logic [DetBits-1:0]       det_abs;
    neg     = t3_det_q[DetBits-1];
    det_abs = neg ? DetBits'(-t3_det_q) : DetBits'(t3_det_q);
    outside = (det_abs == '0);
    for (int l = 0; l < Lanes; l++) begin
      nf[l] = neg ? -NfBits'(t3_n_q[l]) : NfBits'(t3_n_q[l]);
      if (nf[l][NfBits-1]) outside = 1'b1;
    end
    if (en) begin
      t4_bar_q   <= t3_bar_q;
      t4_bn_q    <= t3_bn_q;
      t4_clamp_q <= t3_clamp_q;
      t4_det_q   <= det_abs;
      t4_out_q   <= outside;
      for (int l = 0; l < Lanes; l++) t4_n_q[l] <= nf[l];
    end
  end

  // --------------------------------------------------------------------------
  // Stage T5: select divider operands for the bar or the triangle
  // --------------------------------------------------------------------------
  logic                          t5_v_q;
  logic [Lanes-1:0][N2W-1:0]     t5_num_q;
  logic [Lanes-1:0][D2W-1:0]     t5_den_q;
  logic [Sb2W-1:0]               t5_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t5_v_q <= 1'b0;
    end else if (en) begin
      t5_v_q <= t4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NBits-1:0] nu;
    if (en) begin
      t5_sb_q <= {t4_bar_q, t4_out_q, t4_clamp_q};
      for (int l = 0; l < Lanes; l++) begin
        nu = t4_n_q[l][NBits-1:0];
        if (t4_bar_q) begin
          t5_num_q[l] <= N2W'(t4_bn_q[l]);
          t5_den_q[l] <= D2W'(width_eff);
        end else begin
          // 255 * weight as a shift and subtract
          t5_num_q[l] <= {nu, {CompBits{1'b0}}} - N2W'(nu);
          t5_den_q[l] <= t4_det_q;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider 2: final color quotient with remainder for rounding
  // --------------------------------------------------------------------------
  logic                          d2_v;
  logic [Lanes-1:0][QuoBits-1:0] d2_quo;
  logic [Lanes-1:0][D2W-1:0]     d2_rem, d2_den;
  logic [Sb2W-1:0]               d2_sb;

  bcp_div #(.NW(N2W), .DW(D2W), .SBW(Sb2W)) u_div_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t5_v_q),
    .num_i   (t5_num_q),
    .den_i   (t5_den_q),
    .sb_i    (t5_sb_q),
    .valid_o (d2_v),
    .quo_o   (d2_quo),
    .rem_o   (d2_rem),
    .den_o   (d2_den),
    .sb_o    (d2_sb)
  );

  // round half to even, saturate, and replace outside points with gray
  bcp_out_t res;

  always_comb begin
    logic                is_bar, is_out, up;
    logic [CompBits-1:0] col [Lanes];
    is_bar = d2_sb[Sb2W-1];
    is_out = d2_sb[Sb2W-2];
    for (int l = 0; l < Lanes; l++) begin
      up = ({d2_rem[l], 1'b0} > {1'b0, d2_den[l]})
           || (({d2_rem[l], 1'b0} == {1'b0, d2_den[l]}) && d2_quo[l][0]);
      col[l] = d2_quo[l];
      if (up && (d2_quo[l] != ColorMax)) col[l] = d2_quo[l] + CompBits'(1);
      if (is_bar && d2_sb[l]) col[l] = ColorMax;
      if (!is_bar && is_out) col[l] = GrayLevel;
    end
    res.red              = col[0];
    res.green            = col[1];
    res.blue             = col[2];
    res.in_bar           = is_bar;
    res.outside_triangle = !is_bar && is_out;
  end

  // output register plus skid entry; decouples the pipeline from the sink
  bcp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_o        (en),
    .valid_i     (d2_v),
    .data_i      (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/bcp_div.sv
// ----------------------------------------------------------------------------
// bcp_div: pipelined restoring divider, three lanes
// One quotient bit per stage; the quotient must fit in QuoBits bits.
// ----------------------------------------------------------------------------
module bcp_div #(
  parameter int NW  = 16,
  parameter int DW  = 8,
  parameter int SBW = 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [bcp_pkg::Lanes-1:0][NW-1:0]       num_i,
  input  logic [bcp_pkg::Lanes-1:0][DW-1:0]       den_i,
  input  logic [SBW-1:0]                          sb_i,
  output logic                                    valid_o,
  output logic [bcp_pkg::Lanes-1:0][bcp_pkg::QuoBits-1:0] quo_o,
  output logic [bcp_pkg::Lanes-1:0][DW-1:0]       rem_o,
  output logic [bcp_pkg::Lanes-1:0][DW-1:0]       den_o,
  output logic [SBW-1:0]                          sb_o
);
  import bcp_pkg::*;

  logic                                v_q  [QuoBits];
  logic [Lanes-1:0][NW-1:0]            r_q  [QuoBits];
  logic [Lanes-1:0][DW-1:0]            d_q  [QuoBits];
  logic [Lanes-1:0][QuoBits-1:0]       q_q  [QuoBits];
  logic [SBW-1:0]                      sb_q [QuoBits];

  for (genvar k = 0; k < QuoBits; k++) begin : g_stage
    logic                          v_src;
    logic [Lanes-1:0][NW-1:0]      r_src;
    logic [Lanes-1:0][DW-1:0]      d_src;
    logic [Lanes-1:0][QuoBits-1:0] q_src;
    logic [SBW-1:0]                sb_src;
    logic [Lanes-1:0][NW-1:0]      r_d;
    logic [Lanes-1:0][QuoBits-1:0] q_d;

    if (k == 0) begin : g_first
      assign v_src  = valid_i;
      assign r_src  = num_i;
      assign d_src  = den_i;
      assign q_src  = '0;
      assign sb_src = sb_i;
    end else begin : g_next
      assign v_src  = v_q[k-1];
      assign r_src  = r_q[k-1];
      assign d_src  = d_q[k-1];
      assign q_src  = q_q[k-1];
      assign sb_src = sb_q[k-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    always_comb begin
      logic [NW:0] trial;
      logic [NW:0] dsh;
      for (int l = 0; l < Lanes; l++) begin
        dsh   = (NW+1)'(d_src[l]) << (QuoBits - 1 - k);
        trial = {1'b0, r_src[l]} - dsh;
        if (!trial[NW]) begin
          r_d[l] = trial[NW-1:0];
          q_d[l] = {q_src[l][QuoBits-2:0], 1'b1};
        end else begin
          r_d[l] = r_src[l];
          q_d[l] = {q_src[l][QuoBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= r_d;
        d_q[k]  <= d_src;
        q_q[k]  <= q_d;
        sb_q[k] <= sb_src;
      end
    end
  end

  assign valid_o = v_q[QuoBits-1];
  assign quo_o   = q_q[QuoBits-1];
  assign den_o   = d_q[QuoBits-1];
  assign sb_o    = sb_q[QuoBits-1];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      rem_o[l] = r_q[QuoBits-1][l][DW-1:0];
    end
  end

endmodule

### design/bcp_skid.sv
// ----------------------------------------------------------------------------
// bcp_skid: output register with one skid entry
// Stalls the pipeline only when both entries hold a transaction.
// ----------------------------------------------------------------------------
module bcp_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  output logic              en_o,
  input  logic              valid_i,
  input  bcp_pkg::bcp_out_t data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bcp_pkg::bcp_out_t out_data_o
);
  import bcp_pkg::*;

  logic     ov_q, sv_q;
  bcp_out_t od_q, sd_q;

  assign en_o        = !sv_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (out_ready_i || !ov_q) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= valid_i;
      end
    end else if (valid_i && !sv_q) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !ov_q) begin
      od_q <= sv_q ? sd_q : data_i;
    end else if (valid_i && !sv_q) begin
      sd_q <= data_i;
    end
  end

endmodule

### design/bcp_checker.sv
// ----------------------------------------------------------------------------
// bcp_checker: port-level checks of the color picker
// Watches the handshakes and the consistency of output transactions.
// ----------------------------------------------------------------------------
module bcp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input bcp_pkg::bcp_in_t                in_data_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input bcp_pkg::bcp_out_t               out_data_o,
  input logic                            cfg_we_i,
  input logic [bcp_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input logic [bcp_pkg::CfgDataBits-1:0] cfg_data_i
);
  import bcp_pkg::*;

  // hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // the bar never reports outside
  a_bar_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_bar |-> !out_data_o.outside_triangle)
    else $error("bar result flagged outside");

  // outside points are gray
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outside_triangle |->
      out_data_o.red == GrayLevel && out_data_o.green == GrayLevel
      && out_data_o.blue == GrayLevel)
    else $error("outside result is not gray");

  // input backpressure only while a result is waiting
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !$past(out_ready_i))
    else $error("input stalled without a waiting result");

endmodule

bind barycentric_color_picker_unit bcp_checker u_bcp_checker (.*);
